// ----- hdl/icca_pkg.sv -----
// Shared types, constants and lookup tables of the colour markup translator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package icca_pkg;

    localparam int COLOURS         = 30;
    localparam int ESC_MAX         = 7;
    localparam int LEN_W           = $clog2(ESC_MAX + 1);
    localparam int PTR_W           = $clog2(ESC_MAX);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [4:0] COL_NORMAL = 5'd0;
    localparam logic [4:0] COL_AMP    = 5'd22;
    localparam logic [4:0] COL_BSLASH = 5'd23;

    typedef logic [4:0] colour_t;

    // Byte 0 is the first character sent.
    typedef logic [0:ESC_MAX-1][7:0] str_t;

    typedef struct packed {
        str_t             data;
        logic [LEN_W-1:0] len;
        logic             last;
    } cmd_t;

    typedef enum logic [2:0] {
        LK_NONE,
        LK_COLOUR,
        LK_SETDEF,
        LK_CLRDEF,
        LK_ERROR
    } lkind_t;

    typedef struct packed {
        lkind_t  kind;
        colour_t idx;
    } lcode_t;

    function automatic lcode_t letter_code(logic [7:0] ch);
        lcode_t r;
        r.kind = LK_COLOUR;
        r.idx  = COL_NORMAL;
        case (ch)
            "k":     r.idx = 5'd25;
            "r":     r.idx = 5'd1;
            "g":     r.idx = 5'd2;
            "y":     r.idx = 5'd3;
            "b":     r.idx = 5'd4;
            "m":     r.idx = 5'd5;
            "c":     r.idx = 5'd6;
            "w":     r.idx = 5'd7;
            "K":     r.idx = 5'd29;
            "R":     r.idx = 5'd8;
            "G":     r.idx = 5'd9;
            "Y":     r.idx = 5'd10;
            "B":     r.idx = 5'd11;
            "M":     r.idx = 5'd12;
            "C":     r.idx = 5'd13;
            "W":     r.idx = 5'd14;
            "0":     r.idx = 5'd24;
            "1":     r.idx = 5'd15;
            "2":     r.idx = 5'd16;
            "3":     r.idx = 5'd17;
            "4":     r.idx = 5'd18;
            "5":     r.idx = 5'd19;
            "6":     r.idx = 5'd20;
            "7":     r.idx = 5'd21;
            8'h5C:   r.idx = COL_BSLASH;
            "n":     r.idx = COL_NORMAL;
            "f":     r.idx = 5'd26;
            "v":     r.idx = 5'd27;
            "u":     r.idx = 5'd28;
            "q":     r.kind = LK_SETDEF;
            "Q":     r.kind = LK_CLRDEF;
            "e":     r.kind = LK_ERROR;
            default: r.kind = LK_NONE;
        endcase
        return r;
    endfunction

    function automatic str_t esc_string(colour_t idx);
        str_t s;
        case (idx)
            5'd0:    s = {8'h1B, "[0;0m", 8'h00};
            5'd1:    s = {8'h1B, "[0;31m"};
            5'd2:    s = {8'h1B, "[0;32m"};
            5'd3:    s = {8'h1B, "[0;33m"};
            5'd4:    s = {8'h1B, "[0;34m"};
            5'd5:    s = {8'h1B, "[0;35m"};
            5'd6:    s = {8'h1B, "[0;36m"};
            5'd7:    s = {8'h1B, "[0;37m"};
            5'd8:    s = {8'h1B, "[1;31m"};
            5'd9:    s = {8'h1B, "[1;32m"};
            5'd10:   s = {8'h1B, "[1;33m"};
            5'd11:   s = {8'h1B, "[1;34m"};
            5'd12:   s = {8'h1B, "[1;35m"};
            5'd13:   s = {8'h1B, "[1;36m"};
            5'd14:   s = {8'h1B, "[1;37m"};
            5'd15:   s = {8'h1B, "[41m", 16'h0000};
            5'd16:   s = {8'h1B, "[42m", 16'h0000};
            5'd17:   s = {8'h1B, "[43m", 16'h0000};
            5'd18:   s = {8'h1B, "[44m", 16'h0000};
            5'd19:   s = {8'h1B, "[45m", 16'h0000};
            5'd20:   s = {8'h1B, "[46m", 16'h0000};
            5'd21:   s = {8'h1B, "[47m", 16'h0000};
            5'd22:   s = {8'h26, 48'h0};
            5'd23:   s = {8'h5C, 48'h0};
            5'd24:   s = {8'h1B, "[40m", 16'h0000};
            5'd25:   s = {8'h1B, "[0;30m"};
            5'd26:   s = {8'h1B, "[5m", 24'h000000};
            5'd27:   s = {8'h1B, "[7m", 24'h000000};
            5'd28:   s = {8'h1B, "[4m", 24'h000000};
            5'd29:   s = {8'h1B, "[1;30m"};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [LEN_W-1:0] esc_len(colour_t idx);
        logic [LEN_W-1:0] n;
        case (idx)
            5'd0:                                n = LEN_W'(6);
            5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
            5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
            5'd12, 5'd13, 5'd14, 5'd25, 5'd29:   n = LEN_W'(7);
            5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
            5'd20, 5'd21, 5'd24:                 n = LEN_W'(5);
            5'd22, 5'd23:                        n = LEN_W'(1);
            5'd26, 5'd27, 5'd28:                 n = LEN_W'(4);
            default:                             n = '0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/icca_front.sv -----
// Front end: accepts text bytes, matches markup codes against held look-ahead
// bytes and pushes at most one output command per item. Depends on icca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icca_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           q_full,
    output logic           q_push,
    output icca_pkg::cmd_t q_cmd
);
    import icca_pkg::*;

    typedef enum logic [2:0] {
        ACT_PASS,
        ACT_EXTEND,
        ACT_LETTER,
        ACT_NUM,
        ACT_RAW_ON,
        ACT_RAW_OFF
    } act_t;

    logic       en_reg;
    logic       raw_reg, raw_next;
    colour_t    cur_reg, cur_next;
    colour_t    def_reg, def_next;
    logic [1:0] hcnt_reg, hcnt_next;
    logic [7:0] hold_reg [0:2];

    logic             accept;
    act_t             act;
    lcode_t           lc;
    logic             x_holds;
    logic [7:0]       lit_x;
    logic             emit_x;
    logic [1:0]       lit_cnt;
    str_t             lit_data;
    logic [6:0]       num_val;
    colour_t          num_col;
    logic             set_colour;
    colour_t          shown;
    logic [LEN_W-1:0] shown_len;
    logic             bang;

    function automatic logic is_dig(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign lc       = letter_code(in_byte);
    assign x_holds  = (in_byte == "&" || (in_byte == 8'h5C && !raw_reg)) && !in_last;
    assign lit_x    = (!raw_reg && in_byte == "_") ? " " : in_byte;

    always_comb
    begin
        act = ACT_PASS;
        case (hcnt_reg)
            2'd1:
            begin
                if (hold_reg[0] == "&")
                begin
                    if (raw_reg)
                    begin
                        if (in_byte == "s")
                            act = ACT_RAW_OFF;
                    end
                    else if (in_byte == "S")
                        act = ACT_RAW_ON;
                    else if (lc.kind != LK_NONE)
                        act = ACT_LETTER;
                end
                else if (in_byte == "c")
                    act = ACT_EXTEND;
            end
            2'd2:
            begin
                if (is_dig(in_byte))
                    act = ACT_EXTEND;
            end
            2'd3:
            begin
                if (is_dig(in_byte))
                    act = ACT_NUM;
            end
            default: ;
        endcase
    end

    // Decimal code: low nibbles of ASCII digits carry their value.
    assign num_val = {3'b000, hold_reg[2][3:0]} * 7'd10 + {3'b000, in_byte[3:0]};
    assign num_col = (num_val >= 7'(COLOURS)) ? COL_NORMAL : num_val[4:0];

    assign set_colour = (act == ACT_NUM) || (act == ACT_LETTER && lc.kind == LK_COLOUR);
    assign bang       = (act == ACT_LETTER) && (lc.kind == LK_ERROR)
                        && (cur_reg != COL_NORMAL) && (cur_reg != def_reg);

    always_comb
    begin
        cur_next = cur_reg;
        if (set_colour)
            cur_next = (act == ACT_NUM) ? num_col : lc.idx;
    end

    assign shown     = (cur_next == COL_NORMAL && def_reg != COL_NORMAL) ? def_reg : cur_next;
    assign shown_len = esc_len(shown);

    // Flush held bytes ahead of the new byte when no code forms.
    assign emit_x  = (act == ACT_PASS && !x_holds) || (act == ACT_EXTEND && in_last);
    assign lit_cnt = (act == ACT_PASS || (act == ACT_EXTEND && in_last)) ? hcnt_reg : 2'd0;

    always_comb
    begin
        lit_data = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(lit_cnt))
                lit_data[i] = hold_reg[i];
        end
        if (emit_x)
            lit_data[PTR_W'(lit_cnt)] = lit_x;
    end

    always_comb
    begin
        q_cmd.last = in_last;
        if (set_colour)
        begin
            q_cmd.data = esc_string(shown);
            q_cmd.len  = (en_reg || shown_len == LEN_W'(1)) ? shown_len : '0;
        end
        else if (bang)
        begin
            q_cmd.data = {"!!!", 32'h0};
            q_cmd.len  = LEN_W'(3);
        end
        else
        begin
            q_cmd.data = lit_data;
            q_cmd.len  = LEN_W'(lit_cnt) + LEN_W'(emit_x);
        end
    end

    assign q_push = accept && (q_cmd.len != '0 || in_last);

    always_comb
    begin
        raw_next  = raw_reg;
        def_next  = def_reg;
        hcnt_next = 2'd0;
        if (act == ACT_RAW_ON)
            raw_next = 1'b1;
        if (act == ACT_RAW_OFF)
            raw_next = 1'b0;
        if (act == ACT_LETTER && lc.kind == LK_SETDEF)
            def_next = cur_reg;
        if (act == ACT_LETTER && lc.kind == LK_CLRDEF)
            def_next = COL_NORMAL;
        if (act == ACT_PASS && x_holds)
            hcnt_next = 2'd1;
        if (act == ACT_EXTEND && !in_last)
            hcnt_next = hcnt_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= 1'b1;
            raw_reg  <= 1'b0;
            cur_reg  <= COL_NORMAL;
            def_reg  <= COL_NORMAL;
            hcnt_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                en_reg <= cfg_wdata;
            if (accept)
            begin
                // End of text drops all markup state.
                if (in_last)
                begin
                    raw_reg  <= 1'b0;
                    cur_reg  <= COL_NORMAL;
                    def_reg  <= COL_NORMAL;
                    hcnt_reg <= 2'd0;
                end
                else
                begin
                    raw_reg  <= raw_next;
                    cur_reg  <= cur_next;
                    def_reg  <= def_next;
                    hcnt_reg <= hcnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (act == ACT_PASS && x_holds)
                hold_reg[0] <= in_byte;
            else if (act == ACT_EXTEND && !in_last)
                hold_reg[hcnt_reg] <= in_byte;
        end
    end

`ifndef ASSERT_OFF
    a_hold_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg != 2'd0 |-> (hold_reg[0] == "&" || hold_reg[0] == 8'h5C))
        else $error("held bytes do not start with a code prefix");

    a_raw_hold: assert property (@(posedge clk) disable iff (!rst_n)
        raw_reg |-> (hcnt_reg == 2'd0 || (hcnt_reg == 2'd1 && hold_reg[0] == "&")))
        else $error("raw mode holds more than an ampersand");

    a_colour_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg < 5'(COLOURS)) && (def_reg < 5'(COLOURS)))
        else $error("colour outside table");
`endif

endmodule

`default_nettype wire

// ----- hdl/icca_queue.sv -----
// Command queue between front and back end, registers with one read port.
// Depends on icca_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module icca_queue
#(
    parameter int DEPTH = icca_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  icca_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           pop,
    output icca_pkg::cmd_t rd_cmd,
    output logic           empty
);
    import icca_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [0:DEPTH-1];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- hdl/icca_back.sv -----
// Back end: walks the head command one byte per cycle into the output register while out_ready lets it load.
// Depends on icca_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module icca_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  icca_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           byte_valid,
    output logic           out_last
);
    import icca_pkg::*;

    logic [PTR_W-1:0] ptr_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             byte_valid_reg;
    logic             out_last_reg;

    logic             load;
    logic             at_end;

    assign load   = !out_valid_reg || out_ready;
    assign at_end = (head.len == '0) || (LEN_W'(ptr_reg) == head.len - LEN_W'(1));
    assign pop    = load && !empty && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= !empty;
            if (!empty)
                ptr_reg <= at_end ? '0 : ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            // Empty command is the bare end marker.
            out_byte_reg   <= (head.len != '0) ? head.data[ptr_reg] : 8'h00;
            byte_valid_reg <= (head.len != '0);
            out_last_reg   <= head.last && at_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign out_last   = out_last_reg;

`ifndef ASSERT_OFF
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !byte_valid_reg) |-> out_last_reg)
        else $error("bare marker without end flag");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(ESC_MAX - 1))
        else $error("byte pointer beyond string");

    a_mid_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg != '0 |-> !empty)
        else $error("partly sent command left the queue");
`endif

endmodule

`default_nettype wire

// ----- hdl/inline_colour_code_to_ansi.sv -----
// Top level of the colour markup translator: front end, command queue, back end.
// Depends on icca_pkg, icca_front, icca_queue and icca_back.
//
//   channel  signals                          handshake
//   input    in_byte, in_last                 in_valid / in_ready
//   output   out_byte, byte_valid, out_last   out_valid / out_ready
//   config   cfg_wdata (colour_enable)        cfg_we, no wait
//
// An input item is taken whenever the queue has room; it turns into at most
// one command of 1 to 7 bytes, or an empty command for a bare end marker.
// The back end byte counter sends one byte per cycle while out_ready does not
// hold the output register, and QUEUE_DEPTH commands buffer bursts between
// the two.
// First byte of an item passes through the queue memory and then the back end
// output register before it shows on the outputs.
// Reset sets colour_enable to 1 and clears all markup state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module inline_colour_code_to_ansi
#(
    parameter int QUEUE_DEPTH = icca_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       out_last
);
    import icca_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    icca_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    icca_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (push_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .rd_cmd (head_cmd),
        .empty  (q_empty)
    );

    icca_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .empty      (q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .out_last   (out_last)
    );

endmodule

`default_nettype wire
